@@ hw/rtl/kpd_pkg.sv @@
// kpd_pkg: shared constants, types and helpers for the keypad scan unit
// no dependencies
package kpd_pkg;

    localparam int NUM_KEYS   = 13;
    localparam int KEY_IDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_W      = 4;
    localparam int CNT_W      = 9;
    localparam int NUM_JOY    = 8;
    localparam int NUM_DIGITS = 4;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [CNT_W-1:0] FIRST_DEFAULT = 9'd10;
    localparam logic [CNT_W-1:0] START_DEFAULT = 9'd250;
    localparam logic [CNT_W-1:0] WRAP_DEFAULT  = 9'd351;

    localparam logic [3:0] JOY_CODES [NUM_JOY] = '{
        4'h6, 4'h9, 4'hC, 4'h3, 4'hE, 4'h7, 4'hD, 4'hB
    };

    typedef logic [NUM_KEYS-1:0] kpd_mask_t;
    typedef logic [CNT_W-1:0]    kpd_cnt_t;

    typedef enum logic [1:0] {
        REG_FIRST = 2'd0,
        REG_START = 2'd1,
        REG_WRAP  = 2'd2
    } kpd_reg_t;

    typedef struct packed {
        kpd_cnt_t first;
        kpd_cnt_t start;
        kpd_cnt_t wrap;
    } kpd_cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } kpd_fifo_stat_t;

    function automatic logic key_held(input int k, input logic [3:0] joy,
                                      input logic [3:0] nums, input logic five);
        logic held;
        held = 1'b0;
        if (k < NUM_JOY)
            held = (joy == JOY_CODES[k]);
        else if (k < NUM_JOY + NUM_DIGITS)
            held = !nums[2'(k - NUM_JOY)];
        else if (k == NUM_JOY + NUM_DIGITS)
            held = !five;
        return held;
    endfunction

endpackage

@@ hw/rtl/kpd_if.sv @@
// kpd_if: request channels for scan ticks and key events
// no dependencies
interface kpd_scan_if;
    logic       valid;
    logic       ready;
    logic [3:0] joystick_code;
    logic [3:0] number_row_bits;
    logic       key_five_bit;

    modport source (output valid, output joystick_code, output number_row_bits,
                    output key_five_bit, input ready);
    modport sink   (input valid, input joystick_code, input number_row_bits,
                    input key_five_bit, output ready);
endinterface

interface kpd_evt_if;
    logic       valid;
    logic       ready;
    logic [3:0] key_code;
    logic       last_event;

    modport source (output valid, output key_code, output last_event, input ready);
    modport sink   (input valid, input key_code, input last_event, output ready);
endinterface

@@ hw/rtl/kpd_front.sv @@
// kpd_front: press counters, per-tick event mask generation
// depends on kpd_pkg, kpd_if
module kpd_front
    import kpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    kpd_scan_if.sink         scan,
    input  kpd_cfg_t         cfg,
    input  kpd_fifo_stat_t   fifo_stat,
    output logic             push,
    output kpd_mask_t        push_mask
);

    kpd_cnt_t  cnt_reg  [NUM_KEYS];
    kpd_cnt_t  cnt_next [NUM_KEYS];
    kpd_mask_t mask;
    logic      accept;

    assign scan.ready = !fifo_stat.full;
    assign accept     = scan.valid && scan.ready;

    always_comb
    begin
        kpd_cnt_t c;
        c = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (!key_held(k, scan.joystick_code, scan.number_row_bits, scan.key_five_bit))
            begin
                cnt_next[k] = '0;
                mask[k]     = 1'b0;
            end
            else
            begin
                c = (cnt_reg[k] != CNT_MAX) ? cnt_reg[k] + 1'b1 : cnt_reg[k];
                if (c == cfg.wrap)
                    c = cfg.start;
                cnt_next[k] = c;
                mask[k]     = (c == cfg.first) || (c == cfg.start);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                cnt_reg[k] <= '0;
        end
        else if (accept)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

    // empty ticks produce no events and skip the queue
    assign push      = accept && (mask != '0);
    assign push_mask = mask;

endmodule

@@ hw/rtl/kpd_fifo.sv @@
// kpd_fifo: short queue of event masks between front and back
// depends on kpd_pkg
module kpd_fifo
    import kpd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kpd_mask_t      push_mask,
    input  logic           pop,
    output kpd_mask_t      pop_mask,
    output kpd_fifo_stat_t stat
);

    kpd_mask_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  do_push;
    logic                  do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_mask   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/kpd_back.sv @@
// kpd_back: walks one event mask, one key event per cycle in key order while key_evt.ready is high
// depends on kpd_pkg, kpd_if
module kpd_back
    import kpd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  kpd_fifo_stat_t fifo_stat,
    input  kpd_mask_t      pop_mask,
    output logic           pop,
    kpd_evt_if.source      key_evt
);

    kpd_mask_t            cur_reg;
    kpd_mask_t            cur_next;
    kpd_mask_t            rest;
    logic [KEY_IDX_W-1:0] idx;
    logic                 accept;
    logic                 load;

    // lowest set bit wins
    always_comb
    begin
        idx = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--)
        begin
            if (cur_reg[k])
                idx = KEY_IDX_W'(k);
        end
    end

    assign rest               = cur_reg & (cur_reg - 1'b1);
    assign key_evt.valid      = (cur_reg != '0);
    assign key_evt.key_code   = KEY_W'(idx);
    assign key_evt.last_event = (rest == '0);
    assign accept             = key_evt.valid && key_evt.ready;
    assign load               = !key_evt.valid || (accept && key_evt.last_event);
    assign pop                = load && !fifo_stat.empty;

    always_comb
    begin
        cur_next = cur_reg;
        if (pop)
            cur_next = pop_mask;
        else if (accept)
            cur_next = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_reg <= '0;
        else
            cur_reg <= cur_next;
    end

endmodule

@@ hw/rtl/keypad_scan_debounce_autorepeat_unit.sv @@
// keypad_scan_debounce_autorepeat_unit: top level, config registers and assertions
// depends on kpd_pkg, kpd_if, kpd_front, kpd_fifo, kpd_back
//
//   channel   dir   handshake      payload
//   scan      in    valid/ready    joystick_code, number_row_bits, key_five_bit
//   key_evt   out   valid/ready    key_code, last_event
//   apb       in    psel/penable   paddr, pwdata, prdata (3 count registers)
//
// a scan tick is taken while the mask queue is not full; all counters update at that edge
// a tick's events pass through the mask queue, then the back end's mask register
// the back end walks one key, so one event, per cycle while key_evt.ready is high
// a four-entry mask queue lets scan ticks keep coming while events stall
// reset clears counters, queue and output; registers return to 10, 250, 351
module keypad_scan_debounce_autorepeat_unit
    import kpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    kpd_scan_if.sink          scan,
    kpd_evt_if.source         key_evt,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    kpd_cfg_t       cfg_reg;
    kpd_fifo_stat_t fifo_stat;
    kpd_mask_t      push_mask;
    kpd_mask_t      pop_mask;
    logic           push;
    logic           pop;
    logic           wr_en;
    kpd_reg_t       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = kpd_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first <= FIRST_DEFAULT;
            cfg_reg.start <= START_DEFAULT;
            cfg_reg.wrap  <= WRAP_DEFAULT;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_FIRST: cfg_reg.first <= pwdata[CNT_W-1:0];
                REG_START: cfg_reg.start <= pwdata[CNT_W-1:0];
                REG_WRAP:  cfg_reg.wrap  <= pwdata[CNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FIRST: prdata = DATA_W'(cfg_reg.first);
            REG_START: prdata = DATA_W'(cfg_reg.start);
            REG_WRAP:  prdata = DATA_W'(cfg_reg.wrap);
            default:   prdata = '0;
        endcase
    end

    kpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan      (scan),
        .cfg       (cfg_reg),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_mask (push_mask)
    );

    kpd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_mask (push_mask),
        .pop       (pop),
        .pop_mask  (pop_mask),
        .stat      (fifo_stat)
    );

    kpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .pop_mask  (pop_mask),
        .pop       (pop),
        .key_evt   (key_evt)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_stat.full))
        else $error("mask pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && fifo_stat.empty))
        else $error("mask popped from empty queue");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_evt.valid |-> (key_evt.key_code < KEY_W'(NUM_KEYS)))
        else $error("key code beyond key count");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (key_evt.valid && key_evt.ready && key_evt.last_event && fifo_stat.empty)
        |=> !key_evt.valid)
        else $error("event shown after last of tick with queue empty");

endmodule
